// ===== hdl/rpm_pkg.sv =====
package rpm_pkg;

  localparam int unsigned MAX_NODES          = 3;
  localparam int unsigned NODE_COUNT_DEFAULT = 3;

  localparam int unsigned ID_W       = 8;
  localparam int unsigned TMO_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned NODE_IDX_W = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ID_W-1:0]  NODE0_ID_RESET         = 8'd3;
  localparam logic [ID_W-1:0]  NODE1_ID_RESET         = 8'd1;
  localparam logic [ID_W-1:0]  NODE2_ID_RESET         = 8'd2;
  localparam logic [TMO_W-1:0] RESPONSE_TIMEOUT_RESET = 16'd2;
  localparam logic [TMO_W-1:0] ROUND_GAP_RESET        = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE0_ID         = 3'd0,
    REG_NODE1_ID         = 3'd1,
    REG_NODE2_ID         = 3'd2,
    REG_RESPONSE_TIMEOUT = 3'd3,
    REG_ROUND_GAP        = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_BYTE = 1'b1
  } in_op_t;

  typedef enum logic {
    KIND_POLL  = 1'b0,
    KIND_ANGLE = 1'b1
  } result_kind_t;

  typedef struct packed {
    logic               frame_ok;
    logic               long_frame;
    logic [ID_W-1:0]    first_byte;
    logic [ANGLE_W-1:0] angle;
  } rx_frame_t;

endpackage

// ===== hdl/rpm_rx.sv =====
module rpm_rx
  import rpm_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_valid,
  input  logic [ID_W-1:0] byte_value,
  input  logic            frame_end,
  output rx_frame_t       frame
);

  logic [7:0] rx_sum_r, rx_sum_nxt;
  logic [1:0] rx_pos_r, rx_pos_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] low_r, low_nxt;
  logic [7:0] high_r, high_nxt;

  always_comb begin
    rx_sum_nxt = rx_sum_r + byte_value;
    rx_pos_nxt = (rx_pos_r == 2'd3) ? 2'd3 : rx_pos_r + 2'd1;
    first_nxt  = (rx_pos_r == 2'd0) ? byte_value : first_r;
    low_nxt    = (rx_pos_r == 2'd1) ? byte_value : low_r;
    high_nxt   = (rx_pos_r == 2'd2) ? byte_value : high_r;

    frame.frame_ok   = byte_valid && frame_end && (rx_sum_nxt == 8'd0);
    frame.long_frame = (rx_pos_nxt == 2'd3);
    frame.first_byte = first_nxt;
    frame.angle      = {high_nxt, low_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_sum_r <= '0;
      rx_pos_r <= '0;
    end else if (byte_valid) begin
      if (frame_end) begin
        rx_sum_r <= '0;
        rx_pos_r <= '0;
      end else begin
        rx_sum_r <= rx_sum_nxt;
        rx_pos_r <= rx_pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      low_r   <= '0;
      high_r  <= '0;
    end else if (byte_valid) begin
      first_r <= first_nxt;
      low_r   <= low_nxt;
      high_r  <= high_nxt;
    end
  end

endmodule

// ===== hdl/rs485_polling_master.sv =====
// Output: a result is on out_* in the cycle after the item that causes it is accepted.
// Throughput: one item per cycle unless a held output stalls in_ready; each item is
// finished by compare and add logic between the scheduler and one-deep output registers.
// Reset: synchronous, active low; clears the counters, schedule, receiver and output
// valid, and loads the configuration registers with their default values.
module rs485_polling_master
  import rpm_pkg::*;
#(
  parameter int unsigned NODE_COUNT = NODE_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [ID_W-1:0]       in_byte_value,
  input  logic                  in_frame_end,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_kind,
  output logic [NODE_IDX_W-1:0] out_node_index,
  output logic [ID_W-1:0]       out_node_id,
  output logic [ID_W-1:0]       out_check_byte,
  output logic signed [ANGLE_W-1:0] out_angle
);

  localparam logic [NODE_IDX_W-1:0] LAST_IDX  = NODE_IDX_W'(NODE_COUNT - 1);
  localparam logic [NODE_IDX_W:0]   NODE_CNT  = (NODE_IDX_W+1)'(NODE_COUNT);

  logic [ID_W-1:0]   node_id_r [MAX_NODES];
  logic [TMO_W-1:0]  timeout_r;
  logic [TMO_W-1:0]  gap_r;

  logic [TIME_W-1:0]     tick_r, tick_nxt;
  logic [TIME_W-1:0]     next_send_r, next_send_nxt;
  logic [TIME_W-1:0]     deadline_r, deadline_nxt;
  logic [NODE_IDX_W-1:0] cur_node_r, cur_node_nxt;
  logic                  send_allowed_r, send_allowed_nxt;
  logic                  reply_seen_r, reply_seen_nxt;

  logic                  out_valid_r;
  logic                  out_kind_r;
  logic [NODE_IDX_W-1:0] out_idx_r;
  logic [ID_W-1:0]       out_id_r;
  logic [ID_W-1:0]       out_chk_r;
  logic [ANGLE_W-1:0]    out_angle_r;

  logic                  res_valid;
  result_kind_t          res_kind;
  logic [NODE_IDX_W-1:0] res_idx;
  logic [ID_W-1:0]       res_id;
  logic [ID_W-1:0]       res_chk;
  logic [ANGLE_W-1:0]    res_angle;

  logic                  in_fire;
  logic                  byte_fire;
  rx_frame_t             frame;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign byte_fire = in_fire && (in_op == OP_BYTE);

  rpm_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_fire),
    .byte_value (in_byte_value),
    .frame_end  (in_frame_end),
    .frame      (frame)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r[0] <= NODE0_ID_RESET;
      node_id_r[1] <= NODE1_ID_RESET;
      node_id_r[2] <= NODE2_ID_RESET;
      timeout_r    <= RESPONSE_TIMEOUT_RESET;
      gap_r        <= ROUND_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NODE0_ID:         node_id_r[0] <= cfg_wdata[ID_W-1:0];
        REG_NODE1_ID:         node_id_r[1] <= cfg_wdata[ID_W-1:0];
        REG_NODE2_ID:         node_id_r[2] <= cfg_wdata[ID_W-1:0];
        REG_RESPONSE_TIMEOUT: timeout_r    <= cfg_wdata[TMO_W-1:0];
        REG_ROUND_GAP:        gap_r        <= cfg_wdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [TIME_W-1:0]     tick_inc;
    logic [TIME_W-1:0]     deadline_v;
    logic                  seen_v;
    logic [NODE_IDX_W-1:0] cur_idx;
    logic [ID_W-1:0]       poll_id;
    logic                  hit_found;
    logic [NODE_IDX_W-1:0] hit_idx;
    logic [ID_W-1:0]       hit_id;
    logic                  cur_match;

    tick_nxt         = tick_r;
    next_send_nxt    = next_send_r;
    deadline_nxt     = deadline_r;
    cur_node_nxt     = cur_node_r;
    send_allowed_nxt = send_allowed_r;
    reply_seen_nxt   = reply_seen_r;

    res_valid = 1'b0;
    res_kind  = KIND_POLL;
    res_idx   = '0;
    res_id    = '0;
    res_chk   = '0;
    res_angle = '0;

    tick_inc   = tick_r + TIME_W'(1);
    deadline_v = deadline_r;
    seen_v     = reply_seen_r;
    cur_idx    = ({1'b0, cur_node_r} < NODE_CNT) ? cur_node_r : LAST_IDX;

    poll_id = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (cur_idx == NODE_IDX_W'(i)) begin
        poll_id = node_id_r[i];
      end
    end

    cur_match = 1'b0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (i < NODE_COUNT && cur_node_r == NODE_IDX_W'(i) &&
          node_id_r[i] == frame.first_byte) begin
        cur_match = 1'b1;
      end
    end
    hit_found = cur_match;
    hit_idx   = cur_node_r;
    for (int i = MAX_NODES - 1; i >= 0; i--) begin
      if (!cur_match && i < NODE_COUNT && node_id_r[i] == frame.first_byte) begin
        hit_found = 1'b1;
        hit_idx   = NODE_IDX_W'(i);
      end
    end
    hit_id = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (hit_idx == NODE_IDX_W'(i)) begin
        hit_id = node_id_r[i];
      end
    end

    if (in_fire && in_op == OP_TICK) begin
      tick_nxt = tick_inc;
      if (tick_inc > next_send_r) begin
        if (send_allowed_r) begin
          res_valid        = 1'b1;
          res_kind         = KIND_POLL;
          res_idx          = cur_idx;
          res_id           = poll_id;
          res_chk          = ID_W'(0) - poll_id;
          seen_v           = 1'b0;
          deadline_v       = tick_inc + TIME_W'(timeout_r);
          send_allowed_nxt = 1'b0;
        end
        reply_seen_nxt = seen_v;
        deadline_nxt   = deadline_v;
        if (tick_inc >= deadline_v || seen_v) begin
          send_allowed_nxt = 1'b1;
          if (cur_idx == LAST_IDX) begin
            cur_node_nxt  = '0;
            next_send_nxt = tick_inc + TIME_W'(gap_r);
          end else begin
            cur_node_nxt = cur_idx + NODE_IDX_W'(1);
          end
        end
      end
    end else if (byte_fire && frame.frame_ok) begin
      reply_seen_nxt = 1'b1;
      if (frame.long_frame && hit_found) begin
        res_valid = 1'b1;
        res_kind  = KIND_ANGLE;
        res_idx   = hit_idx;
        res_id    = hit_id;
        res_angle = frame.angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r         <= '0;
      next_send_r    <= '0;
      deadline_r     <= '0;
      cur_node_r     <= '0;
      send_allowed_r <= 1'b0;
      reply_seen_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      tick_r         <= tick_nxt;
      next_send_r    <= next_send_nxt;
      deadline_r     <= deadline_nxt;
      cur_node_r     <= cur_node_nxt;
      send_allowed_r <= send_allowed_nxt;
      reply_seen_r   <= reply_seen_nxt;
      if (in_fire) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      out_kind_r  <= res_kind;
      out_idx_r   <= res_idx;
      out_id_r    <= res_id;
      out_chk_r   <= res_chk;
      out_angle_r <= res_angle;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_node_index = out_idx_r;
  assign out_node_id    = out_id_r;
  assign out_check_byte = out_chk_r;
  assign out_angle      = out_angle_r;

endmodule

// ===== sim/rs485_polling_master_test.sv =====
module rs485_polling_master_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpm_pkg::*;

  localparam int NODES         = NODE_COUNT_DEFAULT;
  localparam int IDLE_PCT      = 11;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 100;
  localparam int HOLD_PHASE    = 5;
  localparam int QUIET_PHASE   = 9;
  localparam int LIMIT_CYCLES  = 300000;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    result_kind_t          kind;
    logic [NODE_IDX_W-1:0] node_index;
    logic [ID_W-1:0]       node_id;
    logic [ID_W-1:0]       check_byte;
    logic [ANGLE_W-1:0]    angle;
  } bus_report_t;

  typedef enum logic [1:0] {
    ROW_ITEM  = 2'd0,
    ROW_TYPED = 2'd1,
    ROW_CFG   = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t             rk;
    in_op_t                op;
    logic [ID_W-1:0]       byte_v;
    logic                  fe;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    logic                  has_report;
    bus_report_t           report;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  in_op_t                in_op         = OP_TICK;
  logic [ID_W-1:0]       in_byte_value = '0;
  logic                  in_frame_end  = 1'b0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic                  out_kind;
  logic [NODE_IDX_W-1:0] out_node_index;
  logic [ID_W-1:0]       out_node_id;
  logic [ID_W-1:0]       out_check_byte;
  logic signed [ANGLE_W-1:0] out_angle;

  // shadow of the master's schedule, receiver and registers
  logic [TIME_W-1:0]     sched_ticks;
  logic [TIME_W-1:0]     sched_next_round;
  logic [TIME_W-1:0]     sched_deadline;
  logic [NODE_IDX_W-1:0] sched_node;
  bit                    sched_may_send;
  bit                    sched_replied;
  logic [ID_W-1:0]       frame_sum;
  logic [1:0]            frame_pos;
  logic [ID_W-1:0]       frame_id;
  logic [ID_W-1:0]       frame_lo;
  logic [ID_W-1:0]       frame_hi;
  logic [ID_W-1:0]       node_ids [NODES];
  logic [TMO_W-1:0]      reply_timeout;
  logic [TMO_W-1:0]      gap_ticks;

  bus_report_t due_reports [$];
  stim_row_t   directed [$];
  bus_report_t want;
  int          fail_count  = 0;
  int          cycle_count = 0;
  int          sent_items  = 0;
  int          hold_left   = 0;
  bit          hold_req    = 0;
  bit          no_gaps     = 0;

  rs485_polling_master u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_byte_value  (in_byte_value),
    .in_frame_end   (in_frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_node_index (out_node_index),
    .out_node_id    (out_node_id),
    .out_check_byte (out_check_byte),
    .out_angle      (out_angle)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_shadow();
    sched_ticks      = '0;
    sched_next_round = '0;
    sched_deadline   = '0;
    sched_node       = '0;
    sched_may_send   = 0;
    sched_replied    = 0;
    frame_sum        = '0;
    frame_pos        = '0;
    frame_id         = '0;
    frame_lo         = '0;
    frame_hi         = '0;
    node_ids[0]      = NODE0_ID_RESET;
    node_ids[1]      = NODE1_ID_RESET;
    node_ids[2]      = NODE2_ID_RESET;
    reply_timeout    = RESPONSE_TIMEOUT_RESET;
    gap_ticks        = ROUND_GAP_RESET;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(idx))
      REG_NODE0_ID:         node_ids[0] = data[ID_W-1:0];
      REG_NODE1_ID:         node_ids[1] = data[ID_W-1:0];
      REG_NODE2_ID:         node_ids[2] = data[ID_W-1:0];
      REG_RESPONSE_TIMEOUT: reply_timeout = data[TMO_W-1:0];
      REG_ROUND_GAP:        gap_ticks = data[TMO_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic bit poll_or_angle(input in_op_t op, input logic [ID_W-1:0] b,
                                       input logic fe, output bus_report_t rep);
    int idx;
    int hit;
    logic [TIME_W-1:0] t;
    bit made;
    made = 0;
    rep  = '0;
    if (op == OP_TICK) begin
      sched_ticks = sched_ticks + 1;
      t = sched_ticks;
      if (t > sched_next_round) begin
        idx = (sched_node < NODES) ? int'(sched_node) : NODES - 1;
        if (sched_may_send) begin
          rep.kind       = KIND_POLL;
          rep.node_index = NODE_IDX_W'(idx);
          rep.node_id    = node_ids[idx];
          rep.check_byte = 8'd0 - node_ids[idx];
          made           = 1;
          sched_replied  = 0;
          sched_deadline = t + TIME_W'(reply_timeout);
          sched_may_send = 0;
        end
        if (t >= sched_deadline || sched_replied) begin
          sched_may_send = 1;
          idx++;
          if (idx >= NODES) begin
            idx = 0;
            sched_next_round = t + TIME_W'(gap_ticks);
          end
          sched_node = NODE_IDX_W'(idx);
        end
      end
    end else begin
      frame_sum = frame_sum + b;
      case (frame_pos)
        2'd0: frame_id = b;
        2'd1: frame_lo = b;
        2'd2: frame_hi = b;
        default: ;
      endcase
      if (frame_pos < 2'd3) frame_pos++;
      if (fe) begin
        if (frame_sum == 8'd0) begin
          sched_replied = 1;
          if (frame_pos == 2'd3) begin
            hit = -1;
            if (sched_node < NODES && node_ids[sched_node] == frame_id) begin
              hit = int'(sched_node);
            end else begin
              for (int i = NODES - 1; i >= 0; i--) begin
                if (node_ids[i] == frame_id) hit = i;
              end
            end
            if (hit >= 0) begin
              rep.kind       = KIND_ANGLE;
              rep.node_index = NODE_IDX_W'(hit);
              rep.node_id    = node_ids[hit];
              rep.angle      = {frame_hi, frame_lo};
              made           = 1;
            end
          end
        end
        frame_sum = '0;
        frame_pos = '0;
      end
    end
    return made;
  endfunction

  function automatic void add_item(in_op_t op, logic [ID_W-1:0] b, logic fe);
    stim_row_t row;
    row        = '0;
    row.rk     = ROW_ITEM;
    row.op     = op;
    row.byte_v = b;
    row.fe     = fe;
    directed.push_back(row);
  endfunction

  function automatic void add_typed(in_op_t op, logic [ID_W-1:0] b, logic fe, logic has,
                                    result_kind_t k, logic [NODE_IDX_W-1:0] idx,
                                    logic [ID_W-1:0] id, logic [ID_W-1:0] chk,
                                    logic [ANGLE_W-1:0] ang);
    stim_row_t row;
    row                   = '0;
    row.rk                = ROW_TYPED;
    row.op                = op;
    row.byte_v            = b;
    row.fe                = fe;
    row.has_report        = has;
    row.report.kind       = k;
    row.report.node_index = idx;
    row.report.node_id    = id;
    row.report.check_byte = chk;
    row.report.angle      = ang;
    directed.push_back(row);
  endfunction

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row          = '0;
    row.rk       = ROW_CFG;
    row.reg_idx  = idx;
    row.reg_data = data;
    directed.push_back(row);
  endfunction

  task automatic send_item(input in_op_t op, input logic [ID_W-1:0] b, input logic fe,
                           input bit typed, input bit has_rep, input bus_report_t typed_rep);
    bus_report_t rep;
    bit made;
    while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_byte_value <= b;
    in_frame_end  <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    made = poll_or_angle(op, b, fe, rep);
    if (typed) begin
      if (has_rep) due_reports.push_back(typed_rep);
    end else if (made) begin
      due_reports.push_back(rep);
    end
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len, input logic [ID_W-1:0] first, input bit corrupt);
    logic [ID_W-1:0] sum;
    logic [ID_W-1:0] b;
    sum = '0;
    for (int k = 0; k < len; k++) begin
      if (k == len - 1) begin
        b = 8'd0 - sum;
        if (corrupt) b = b ^ 8'($urandom_range(1, 255));
      end else if (k == 0) begin
        b = first;
      end else begin
        b = 8'($urandom);
      end
      sum = sum + b;
      send_item(OP_BYTE, b, k == len - 1, 0, 0, '0);
    end
  endtask

  // drop valid and let every pending item drain before touching registers
  task automatic drain_block();
    in_valid <= 1'b0;
    @(negedge clk);
    while (due_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic pick_settings(input int phase);
    logic [ID_W-1:0]  ids [NODES];
    logic [TMO_W-1:0] tmo;
    logic [TMO_W-1:0] gp;
    for (int i = 0; i < NODES; i++) ids[i] = 8'($urandom);
    tmo = TMO_W'($urandom_range(0, 6));
    gp  = TMO_W'($urandom_range(0, 12));
    if ($urandom_range(0, 3) == 0) ids[$urandom_range(1, NODES - 1)] = ids[0];
    if ($urandom_range(0, 7) == 0) tmo = TMO_W'($urandom_range(20, 300));
    if (phase == 0) begin
      ids[0] = 8'hFF;
      ids[1] = 8'h00;
      ids[2] = 8'h00;
      tmo    = '0;
      gp     = '0;
    end else if (phase == PHASES - 1) begin
      tmo = '1;
      gp  = '1;
    end
    for (int i = 0; i < NODES; i++) begin
      write_reg(CFG_IDX_W'(REG_NODE0_ID + i), {8'h00, ids[i]});
    end
    write_reg(REG_RESPONSE_TIMEOUT, tmo);
    write_reg(REG_ROUND_GAP, gp);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_UNUSED_LAST)), 16'($urandom));
    end
  endtask

  task automatic random_action();
    int pick;
    int len;
    logic [ID_W-1:0] first;
    pick  = $urandom_range(0, 99);
    len   = $urandom_range(0, 9);
    len   = (len == 0) ? 1 : (len == 1) ? 2 : $urandom_range(3, 6);
    first = ($urandom_range(0, 9) < 7) ? node_ids[$urandom_range(0, NODES - 1)]
                                       : 8'($urandom);
    if (pick < 45) begin
      send_item(OP_TICK, 8'($urandom), 1'($urandom), 0, 0, '0);
    end else if (pick < 85) begin
      send_frame(len, first, 0);
    end else if (pick < 92) begin
      send_frame(len, first, 1);
    end else begin
      send_item(in_op_t'($urandom_range(0, 1)), 8'($urandom), 1'($urandom), 0, 0, '0);
    end
  endtask

  initial begin
    int start;
    reset_shadow();

    add_typed(OP_TICK, 8'h00, 1'b0, 0, KIND_POLL, 2'd0, 8'h00, 8'h00, 16'h0000);
    add_typed(OP_TICK, 8'h00, 1'b0, 1, KIND_POLL, 2'd1, 8'h01, 8'hFF, 16'h0000);
    add_item(OP_BYTE, 8'h01, 1'b0);
    add_item(OP_BYTE, 8'h34, 1'b0);
    add_item(OP_BYTE, 8'h12, 1'b0);
    add_typed(OP_BYTE, 8'hB9, 1'b1, 1, KIND_ANGLE, 2'd1, 8'h01, 8'h00, 16'h1234);
    add_item(OP_TICK, 8'hFF, 1'b1);
    add_item(OP_TICK, 8'h00, 1'b0);
    // short frame, then unknown id, then bad checksum
    add_item(OP_BYTE, 8'h05, 1'b0);
    add_typed(OP_BYTE, 8'hFB, 1'b1, 0, KIND_POLL, 2'd0, 8'h00, 8'h00, 16'h0000);
    add_item(OP_BYTE, 8'h09, 1'b0);
    add_item(OP_BYTE, 8'h00, 1'b0);
    add_typed(OP_BYTE, 8'hF7, 1'b1, 0, KIND_POLL, 2'd0, 8'h00, 8'h00, 16'h0000);
    add_item(OP_BYTE, 8'h01, 1'b0);
    add_item(OP_BYTE, 8'h02, 1'b0);
    add_typed(OP_BYTE, 8'h03, 1'b1, 0, KIND_POLL, 2'd0, 8'h00, 8'h00, 16'h0000);
    add_item(OP_BYTE, 8'h03, 1'b0);
    add_item(OP_BYTE, 8'h00, 1'b0);
    add_item(OP_BYTE, 8'h80, 1'b0);
    add_typed(OP_BYTE, 8'h7D, 1'b1, 1, KIND_ANGLE, 2'd0, 8'h03, 8'h00, 16'h8000);
    add_item(OP_BYTE, 8'h01, 1'b0);
    add_item(OP_BYTE, 8'hFF, 1'b0);
    add_item(OP_BYTE, 8'h7F, 1'b0);
    add_typed(OP_BYTE, 8'h81, 1'b1, 1, KIND_ANGLE, 2'd1, 8'h01, 8'h00, 16'h7FFF);
    // duplicate ids, zero timeout and zero gap
    add_reg(REG_NODE0_ID, 16'h0000);
    add_reg(REG_NODE1_ID, 16'h0000);
    add_reg(REG_NODE2_ID, 16'h00FF);
    add_reg(REG_RESPONSE_TIMEOUT, 16'h0000);
    add_reg(REG_ROUND_GAP, 16'h0000);
    add_reg(REG_UNUSED_LAST, 16'hFFFF);
    add_item(OP_TICK, 8'h00, 1'b0);
    add_item(OP_TICK, 8'h00, 1'b0);
    add_item(OP_BYTE, 8'h00, 1'b0);
    add_item(OP_BYTE, 8'h11, 1'b0);
    add_item(OP_BYTE, 8'h22, 1'b0);
    add_item(OP_BYTE, 8'hCD, 1'b1);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      case (directed[i].rk)
        ROW_CFG: begin
          drain_block();
          write_reg(directed[i].reg_idx, directed[i].reg_data);
        end
        ROW_TYPED: send_item(directed[i].op, directed[i].byte_v, directed[i].fe, 1,
                             directed[i].has_report, directed[i].report);
        default: send_item(directed[i].op, directed[i].byte_v, directed[i].fe, 0, 0, '0);
      endcase
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      drain_block();
      pick_settings(phase);
      no_gaps = (phase == QUIET_PHASE);
      if (phase == HOLD_PHASE) hold_req = 1;
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) random_action();
    end

    drain_block();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        $error("unexpected item: kind %0d node_id %0d", out_kind, out_node_id);
        fail_count++;
      end else begin
        want = due_reports.pop_front();
        if (out_kind !== want.kind) begin
          $error("kind expected %0d actual %0d", want.kind, out_kind);
          fail_count++;
        end
        if (out_node_index !== want.node_index) begin
          $error("node_index expected %0d actual %0d", want.node_index, out_node_index);
          fail_count++;
        end
        if (out_node_id !== want.node_id) begin
          $error("node_id expected %0d actual %0d", want.node_id, out_node_id);
          fail_count++;
        end
        if (out_check_byte !== want.check_byte) begin
          $error("check_byte expected %0d actual %0d", want.check_byte, out_check_byte);
          fail_count++;
        end
        if (out_angle !== want.angle) begin
          $error("angle expected %0d actual %0d", $signed(want.angle), out_angle);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
